>>> rtl/bef_pkg.sv
// Shared types, widths and command codes for the byte escape formatter.
`timescale 1ns / 1ps
`default_nettype none
package bef_pkg;

  // Field widths
  localparam int CAP_W  = 16;
  localparam int CNT_W  = 20;
  localparam int CMD_W  = 2;
  localparam int BYTE_W = 8;

  // Saturation limit of the required-length count
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Request queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Output stream packing: out_char, then required_length, padded to bytes
  localparam int OUT_TDATA_W = ((BYTE_W + CNT_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - BYTE_W - CNT_W;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_BEGIN = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DATA  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_END   = 2'd2;

  // Characters used by the escapes
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TILDE  = 8'h7E;
  localparam logic [7:0] CH_NUL    = 8'h00;

  // One escape (or terminator) waiting for the back end
  typedef struct packed {
    logic [3:0][7:0]  chars;    // chars[0] goes out first
    logic [1:0]       len_m1;   // character count minus one
    logic             term;
    logic             written;
    logic [CNT_W-1:0] req_len;
  } bef_entry_t;

endpackage
`default_nettype wire

>>> rtl/bef_front.sv
// Front end: takes requests, holds budget and count, builds the escape.
`timescale 1ns / 1ps
`default_nettype none
module bef_front (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_wr_en,
  input  wire logic [bef_pkg::CAP_W-1:0] cfg_wr_data,
  input  wire logic                      in_tvalid,
  output logic                           in_tready,
  input  wire logic [bef_pkg::CMD_W-1:0] in_command,
  input  wire logic [7:0]                in_data_byte,
  input  wire logic                      q_full,
  output logic                           q_push,
  output bef_pkg::bef_entry_t            q_wdata
);
  import bef_pkg::*;

  logic [CAP_W-1:0] capacity_r;
  logic [CAP_W-1:0] budget_r;
  logic [CAP_W-1:0] budget_nxt;
  logic [CNT_W-1:0] needed_r;
  logic [CNT_W-1:0] needed_nxt;

  logic             accept;
  logic             is_data;
  logic             is_begin;
  logic             is_end;
  logic [3:0][7:0]  esc_chars;
  logic [1:0]       esc_len_m1;
  logic [2:0]       esc_len;
  logic             fits;
  logic [CNT_W:0]   sum;

  // Hex digit in upper case
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] r;
    if (nib < 4'd10) begin
      r = 8'h30 + {4'd0, nib};
    end else begin
      r = 8'h37 + {4'd0, nib};
    end
    return r;
  endfunction

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign is_begin  = (in_command == CMD_BEGIN);
  assign is_data   = (in_command == CMD_DATA);
  assign is_end    = (in_command == CMD_END);

  // Escape classification
  always_comb begin
    esc_chars  = '0;
    esc_len_m1 = 2'd0;
    if (in_data_byte >= CH_SPACE && in_data_byte <= CH_TILDE &&
        in_data_byte != CH_BSLASH) begin
      esc_chars[0] = in_data_byte;
    end else if (in_data_byte == CH_BSLASH) begin
      esc_chars[0] = CH_BSLASH;
      esc_chars[1] = CH_BSLASH;
      esc_len_m1   = 2'd1;
    end else if (in_data_byte >= 8'h09 && in_data_byte <= 8'h0D) begin
      esc_chars[0] = CH_BSLASH;
      esc_len_m1   = 2'd1;
      case (in_data_byte[2:0])
        3'd1:    esc_chars[1] = 8'h68; // h
        3'd2:    esc_chars[1] = 8'h6E; // n
        3'd3:    esc_chars[1] = 8'h76; // v
        3'd4:    esc_chars[1] = 8'h6C; // l
        default: esc_chars[1] = 8'h72; // r
      endcase
    end else begin
      esc_chars[0] = CH_BSLASH;
      esc_chars[1] = CH_X;
      esc_chars[2] = hex_char(in_data_byte[7:4]);
      esc_chars[3] = hex_char(in_data_byte[3:0]);
      esc_len_m1   = 2'd3;
    end
  end

  assign esc_len = {1'b0, esc_len_m1} + 3'd1;
  assign fits    = (budget_r > {{(CAP_W-3){1'b0}}, esc_len});
  assign sum     = {1'b0, needed_r} + {{(CNT_W-2){1'b0}}, esc_len};

  // State update
  always_comb begin
    budget_nxt = budget_r;
    needed_nxt = needed_r;
    if (accept && is_begin) begin
      budget_nxt = capacity_r;
      needed_nxt = {{(CNT_W-1){1'b0}}, 1'b1};
    end else if (accept && is_data) begin
      needed_nxt = sum[CNT_W] ? CNT_MAX : sum[CNT_W-1:0];
      if (fits) begin
        budget_nxt = budget_r - {{(CAP_W-3){1'b0}}, esc_len};
      end
    end
  end

  // Queue request
  always_comb begin
    q_push  = accept && (is_data || is_end);
    q_wdata = '0;
    if (is_end) begin
      q_wdata.chars[0] = CH_NUL;
      q_wdata.term     = 1'b1;
      q_wdata.written  = (budget_r != '0);
      q_wdata.req_len  = needed_r;
    end else begin
      q_wdata.chars    = esc_chars;
      q_wdata.len_m1   = esc_len_m1;
      q_wdata.written  = fits;
      q_wdata.req_len  = needed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= '0;
      budget_r   <= '0;
      needed_r   <= {{(CNT_W-1){1'b0}}, 1'b1};
    end else begin
      if (cfg_wr_en) begin
        capacity_r <= cfg_wr_data;
      end
      budget_r <= budget_nxt;
      needed_r <= needed_nxt;
    end
  end

`ifndef SYNTHESIS
  // Budget only grows on a begin request
  a_budget_mono: assert property (@(posedge clk) disable iff (!rst_n)
    !(accept && is_begin) |=> budget_r <= $past(budget_r))
    else $error("budget grew without begin");
  // Required length never drops to zero
  a_needed_nz: assert property (@(posedge clk) disable iff (!rst_n)
    needed_r != '0)
    else $error("required length is zero");
`endif

endmodule
`default_nettype wire

>>> rtl/bef_queue.sv
// Short request queue between front and back ends.
`timescale 1ns / 1ps
`default_nettype none
module bef_queue (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire bef_pkg::bef_entry_t wdata,
  input  wire logic                pop,
  output bef_pkg::bef_entry_t      rdata,
  output logic                     valid,
  output logic                     full
);
  import bef_pkg::*;

  bef_entry_t        mem_r [QDEPTH];
  logic [QPTR_W-1:0] wptr_r;
  logic [QPTR_W-1:0] rptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_push;
  logic              do_pop;

  assign valid   = (cnt_r != '0);
  assign full    = (cnt_r == QCNT_W'(QDEPTH));
  assign rdata   = mem_r[rptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (do_pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  // Count never passes the depth
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QDEPTH))
    else $error("queue overfilled");
  // Front never pushes into a full queue
  a_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("push while full");
`endif

endmodule
`default_nettype wire

>>> rtl/bef_back.sv
// Back end: streams the characters of each queued escape, one per cycle while the output is not stalled.
`timescale 1ns / 1ps
`default_nettype none
module bef_back (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire bef_pkg::bef_entry_t       q_rdata,
  input  wire logic                      q_valid,
  output logic                           q_pop,
  input  wire logic                      out_tready,
  output logic                           out_valid,
  output logic [7:0]                     out_char,
  output logic                           out_term,
  output logic                           out_written,
  output logic [bef_pkg::CNT_W-1:0]      out_req_len,
  output logic                           out_last
);
  import bef_pkg::*;

  bef_entry_t       cur_r;
  logic             cur_valid_r;
  logic [1:0]       idx_r;
  logic [1:0]       idx_nxt;
  logic             out_valid_r;
  logic [7:0]       out_char_r;
  logic             out_term_r;
  logic             out_written_r;
  logic [CNT_W-1:0] out_req_r;
  logic             out_last_r;
  logic             out_load;
  logic             cur_last;
  logic             emit;

  assign out_load = !out_valid_r || out_tready;
  assign cur_last = (idx_r == cur_r.len_m1);
  assign emit     = out_load && cur_valid_r;
  assign q_pop    = q_valid && (!cur_valid_r || (emit && cur_last));
  assign idx_nxt  = cur_last ? 2'd0 : idx_r + 2'd1;

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else begin
      if (out_load) begin
        out_valid_r <= cur_valid_r;
      end
      if (emit) begin
        idx_r <= idx_nxt;
      end
      if (q_pop) begin
        cur_valid_r <= 1'b1;
      end else if (emit && cur_last) begin
        cur_valid_r <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_rdata;
    end
    if (emit) begin
      out_char_r    <= cur_r.chars[idx_r];
      out_term_r    <= cur_r.term;
      out_written_r <= cur_r.written;
      out_req_r     <= cur_r.req_len;
      out_last_r    <= cur_last;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_char    = out_char_r;
  assign out_term    = out_term_r;
  assign out_written = out_written_r;
  assign out_req_len = out_req_r;
  assign out_last    = out_last_r;

`ifndef SYNTHESIS
  // A terminator is always the only result of its request
  a_term_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_term_r |-> out_last_r)
    else $error("terminator without last");
  // Character index never runs past the escape length
  a_idx_rng: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r |-> idx_r <= cur_r.len_m1)
    else $error("character index out of range");
`endif

endmodule
`default_nettype wire

>>> rtl/byte_escape_formatter.sv
// Top level of the byte escape formatter: front end, request queue, back end.
//
//  channel | direction | tdata                                 | tuser           | tlast
//  in_     | slave     | [7:0] data_byte                       | [1:0] command   | -
//  out_    | master    | [7:0] out_char, [27:8] required_length| [0] is_term,    | last
//          |           |                                       | [1] char_written|
//  cfg_    | write     | cfg_wr_data: out_capacity             | -               | -
//
// A data byte produces 1, 2 or 4 output characters, one per cycle on the output
// register while the output is not stalled; an end request gives one, a begin
// none. The output character rate sets throughput, and a new request is taken
// every cycle while the 4-entry queue has room. Reset (rst_n low, synchronous)
// clears budget to 0, count to 1, capacity to 0 and empties the queue. Output
// stalls back up through the queue and then drop in_tready.
`timescale 1ns / 1ps
`default_nettype none
module byte_escape_formatter (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_wr_en,
  input  wire logic [bef_pkg::CAP_W-1:0]       cfg_wr_data,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [7:0]                      in_tdata,   // [7:0] data_byte
  input  wire logic [1:0]                      in_tuser,   // [1:0] command
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [bef_pkg::OUT_TDATA_W-1:0]      out_tdata,  // out_char, required_length
  output logic [1:0]                           out_tuser,  // is_terminator, char_written
  output logic                                 out_tlast
);
  import bef_pkg::*;

  bef_entry_t       q_wdata;
  bef_entry_t       q_rdata;
  logic             q_push;
  logic             q_pop;
  logic             q_valid;
  logic             q_full;
  logic [7:0]       o_char;
  logic             o_term;
  logic             o_written;
  logic [CNT_W-1:0] o_req;

  bef_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_command   (in_tuser),
    .in_data_byte (in_tdata),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_wdata      (q_wdata)
  );

  bef_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .valid (q_valid),
    .full  (q_full)
  );

  bef_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_rdata     (q_rdata),
    .q_valid     (q_valid),
    .q_pop       (q_pop),
    .out_tready  (out_tready),
    .out_valid   (out_tvalid),
    .out_char    (o_char),
    .out_term    (o_term),
    .out_written (o_written),
    .out_req_len (o_req),
    .out_last    (out_tlast)
  );

  // Stream packing
  assign out_tdata = {{OUT_PAD_W{1'b0}}, o_req, o_char};
  assign out_tuser = {o_written, o_term};

endmodule
`default_nettype wire
